// ----- hw/rtl/interrupt_controller_init_write_top_macros.svh -----
// Assertion macros shared by the interrupt controller write-side RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef INTERRUPT_CONTROLLER_INIT_WRITE_TOP_MACROS_SVH
`define INTERRUPT_CONTROLLER_INIT_WRITE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ICW_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled while reset is high
`define ICW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- hw/rtl/icw_pkg.sv -----
// Types and constants for the cascaded interrupt controller write side.
// Depends on nothing; imported by interrupt_controller_init_write_top.
package icw_pkg;

   // Initialization phase of one controller
   typedef enum logic [1:0] {
      PHASE_READY = 2'd0,
      PHASE_ICW2  = 2'd1,
      PHASE_ICW3  = 2'd2,
      PHASE_ICW4  = 2'd3
   } phase_type;

   // Chip select values
   localparam logic CHIP_MASTER = 1'b0;
   localparam logic CHIP_SLAVE  = 1'b1;

   // Port address bits
   localparam int PORT_SLAVE_BIT = 7;
   localparam int PORT_DATA_BIT  = 0;

   // Command byte bits
   localparam int CMD_INIT_BIT   = 4;
   localparam int CMD_IC4_BIT    = 0;
   localparam int CMD_SINGLE_BIT = 1;

   // ICW4 auto end-of-interrupt bit
   localparam int ICW4_AEOI_BIT = 1;

   // Vector base handling
   localparam logic [7:0] BASE_MASK        = 8'hF8;
   localparam logic [7:0] MASTER_BASE_RST  = 8'h08;
   localparam logic [7:0] SLAVE_BASE_RST   = 8'h70;

   // One port write
   typedef struct packed {
      logic [7:0] port_addr;
      logic [7:0] data;
   } req_type;

   // Addressed chip's state after the write
   typedef struct packed {
      logic       ignored;
      logic       chip;
      logic [1:0] init_phase;
      logic [7:0] irq_mask;
      logic [7:0] vector_base;
      logic       auto_eoi_on;
      logic       slave_present;
   } rsp_type;

endpackage

// ----- hw/rtl/interrupt_controller_init_write_top.sv -----
// Write side of a cascaded master/slave pair of 8259-style controllers.
// Usage:
//   req_* carries one port write (port_addr, data) per beat; bit 7 of the
//   port picks the slave, bit 0 picks data versus command.
//   rsp_* returns one beat per write: the addressed chip's phase, mask,
//   vector base, auto-EOI flag, slave presence, and an ignored flag for a
//   write to an absent slave (which changes nothing).
// Timing:
//   A taken write goes first into the input register, where the state
//   update and result are formed, then into the result register, from
//   which the result beat is offered.
//   One write per cycle is sustained while rsp_ready stays high; the state
//   registers update in the same cycle the write leaves the input register,
//   so the next write sees them at once.
// Reset: both chips return to ready with mask 0, bases 0x08 and 0x70,
//   auto-EOI off, slave present, and both pipeline stages empty.
// Stall: with rsp_ready low the result register holds; the input register
//   holds behind it, and req_ready drops once both are full.
// Depends on icw_pkg and interrupt_controller_init_write_top_macros.svh.
`include "interrupt_controller_init_write_top_macros.svh"

module interrupt_controller_init_write_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  icw_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output icw_pkg::rsp_type rsp_payload
);
   import icw_pkg::*;

   // Pipeline registers
   logic      in_valid_ff;
   req_type   in_ff;
   logic      out_valid_ff;
   rsp_type   out_ff;
   rsp_type   out_in;

   // Controller state, index 0 master, 1 slave
   phase_type       phase_ff [2];
   phase_type       phase_in [2];
   logic [1:0]      expect_ff;
   logic [1:0]      expect_in;
   logic [1:0][7:0] base_ff;
   logic [1:0][7:0] base_in;
   logic [1:0][7:0] mask_ff;
   logic [1:0][7:0] mask_in;
   logic [1:0]      aeoi_ff;
   logic [1:0]      aeoi_in;
   logic            cascade_ff;
   logic            cascade_in;

   // Handshake control
   logic out_free;
   logic advance;
   logic chip_sel;
   logic is_data;
   logic ignore_wr;
   logic [7:0] wr_data;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   assign chip_sel  = in_ff.port_addr[PORT_SLAVE_BIT];
   assign is_data   = in_ff.port_addr[PORT_DATA_BIT];
   assign wr_data   = in_ff.data;
   assign ignore_wr = (chip_sel == CHIP_SLAVE) && !cascade_ff;

   // Form next controller state from the write in the input register
   always_comb begin
      phase_in   = phase_ff;
      expect_in  = expect_ff;
      base_in    = base_ff;
      mask_in    = mask_ff;
      aeoi_in    = aeoi_ff;
      cascade_in = cascade_ff;
      if (advance && !ignore_wr) begin
         if (!is_data) begin
            if (wr_data[CMD_INIT_BIT]) begin
               phase_in[chip_sel] = PHASE_ICW2;
            end
            expect_in[chip_sel] = wr_data[CMD_IC4_BIT];
            if (chip_sel == CHIP_MASTER) begin
               cascade_in = !wr_data[CMD_SINGLE_BIT];
            end
         end else begin
            case (phase_ff[chip_sel])
               PHASE_READY: begin
                  mask_in[chip_sel] = wr_data;
               end
               PHASE_ICW2: begin
                  base_in[chip_sel] = wr_data & BASE_MASK;
                  if (cascade_ff) begin
                     phase_in[chip_sel] = PHASE_ICW3;
                  end else if (expect_ff[chip_sel]) begin
                     phase_in[chip_sel] = PHASE_ICW4;
                  end else begin
                     phase_in[chip_sel] = PHASE_READY;
                  end
               end
               PHASE_ICW3: begin
                  phase_in[chip_sel] = expect_ff[chip_sel] ? PHASE_ICW4 : PHASE_READY;
               end
               default: begin
                  aeoi_in[chip_sel]  = wr_data[ICW4_AEOI_BIT];
                  phase_in[chip_sel] = PHASE_READY;
               end
            endcase
         end
      end
   end

   // Report the addressed chip after the write
   always_comb begin
      out_in               = '0;
      out_in.ignored       = ignore_wr;
      out_in.chip          = chip_sel;
      out_in.init_phase    = phase_in[chip_sel];
      out_in.irq_mask      = mask_in[chip_sel];
      out_in.vector_base   = base_in[chip_sel] & BASE_MASK;
      out_in.auto_eoi_on   = aeoi_in[chip_sel];
      out_in.slave_present = cascade_in;
   end

   // Input register: take a beat whenever it is empty or draining
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_ff <= req_payload;
      end
   end

   // Result register: load on advance, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   // Controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff[0] <= PHASE_READY;
         phase_ff[1] <= PHASE_READY;
         expect_ff   <= '0;
         base_ff[0]  <= MASTER_BASE_RST;
         base_ff[1]  <= SLAVE_BASE_RST;
         mask_ff     <= '0;
         aeoi_ff     <= '0;
         cascade_ff  <= 1'b1;
      end else begin
         phase_ff   <= phase_in;
         expect_ff  <= expect_in;
         base_ff    <= base_in;
         mask_ff    <= mask_in;
         aeoi_ff    <= aeoi_in;
         cascade_ff <= cascade_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   // An ignored write always names the slave while it is absent
   `ICW_ASSERT_IMPLY(a_ignored_slave, clock, reset,
      out_valid_ff && out_ff.ignored,
      out_ff.chip == CHIP_SLAVE && !out_ff.slave_present)
   // Reported vector base is always a multiple of eight
   `ICW_ASSERT_IMPLY(a_base_aligned, clock, reset, out_valid_ff, out_ff.vector_base[2:0] == 3'b000)
   // A write to an absent slave leaves the stored state untouched
   `ICW_ASSERT_NEXT(a_ignored_no_change, clock, reset, advance && ignore_wr,
      mask_ff == $past(mask_ff) && base_ff == $past(base_ff) &&
      cascade_ff == $past(cascade_ff))
   // A blocked input beat stays in the input register
   `ICW_ASSERT_NEXT(a_input_holds, clock, reset, in_valid_ff && !out_free,
      in_valid_ff && in_ff == $past(in_ff))

endmodule

// ----- tb/icw_write_checker.sv -----
// Checker for the cascaded interrupt controller write side: predicts each
// result beat from the accepted request beats and compares field by field.
// Depends on icw_pkg for the payload types, phase codes and bit positions.
module icw_write_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  icw_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  icw_pkg::rsp_type rsp_payload,
   output int               fail_count,
   output int               outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import icw_pkg::*;

   // Shadow copy of both controllers
   phase_type  phase_q [2];
   logic       icw4_wanted_q [2];
   logic [7:0] base_q [2];
   logic [7:0] mask_q [2];
   logic       aeoi_q [2];
   logic       slave_on_q;

   // Predicted result beats, oldest first
   rsp_type predicted_states [$];

   // Apply one port write to the shadow state and return the chip's view
   function automatic rsp_type apply_port_write(req_type w);
      rsp_type r;
      logic    c;
      logic    dropped;
      c       = w.port_addr[PORT_SLAVE_BIT];
      dropped = (c == CHIP_SLAVE) && !slave_on_q;
      if (!dropped) begin
         if (!w.port_addr[PORT_DATA_BIT]) begin
            // command: optional init restart, latch flags
            if (w.data[CMD_INIT_BIT])
               phase_q[c] = PHASE_ICW2;
            icw4_wanted_q[c] = w.data[CMD_IC4_BIT];
            if (c == CHIP_MASTER)
               slave_on_q = !w.data[CMD_SINGLE_BIT];
         end else begin
            case (phase_q[c])
               PHASE_READY: mask_q[c] = w.data;
               PHASE_ICW2: begin
                  base_q[c] = w.data & BASE_MASK;
                  if (slave_on_q)
                     phase_q[c] = PHASE_ICW3;
                  else
                     phase_q[c] = icw4_wanted_q[c] ? PHASE_ICW4 : PHASE_READY;
               end
               PHASE_ICW3: phase_q[c] = icw4_wanted_q[c] ? PHASE_ICW4 : PHASE_READY;
               default: begin
                  aeoi_q[c]  = w.data[ICW4_AEOI_BIT];
                  phase_q[c] = PHASE_READY;
               end
            endcase
         end
      end
      r.ignored       = dropped;
      r.chip          = c;
      r.init_phase    = phase_q[c];
      r.irq_mask      = mask_q[c];
      r.vector_base   = base_q[c] & BASE_MASK;
      r.auto_eoi_on   = aeoi_q[c];
      r.slave_present = slave_on_q;
      return r;
   endfunction

   // Compare one field and log any difference
   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: mismatch in %s: expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase_q       = '{PHASE_READY, PHASE_READY};
         icw4_wanted_q = '{1'b0, 1'b0};
         base_q        = '{MASTER_BASE_RST, SLAVE_BASE_RST};
         mask_q        = '{8'h00, 8'h00};
         aeoi_q        = '{1'b0, 1'b0};
         slave_on_q    = 1'b1;
         predicted_states.delete();
      end else begin
         // retire a result beat against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (predicted_states.size() == 0) begin
               $display("%0t: result beat with nothing expected, actual %0h", $time,
                        rsp_payload);
               fail_count++;
            end else begin
               rsp_type want;
               want = predicted_states.pop_front();
               check_field("ignored", 8'(want.ignored), 8'(rsp_payload.ignored));
               check_field("chip", 8'(want.chip), 8'(rsp_payload.chip));
               check_field("init_phase", 8'(want.init_phase), 8'(rsp_payload.init_phase));
               check_field("irq_mask", want.irq_mask, rsp_payload.irq_mask);
               check_field("vector_base", want.vector_base, rsp_payload.vector_base);
               check_field("auto_eoi_on", 8'(want.auto_eoi_on), 8'(rsp_payload.auto_eoi_on));
               check_field("slave_present", 8'(want.slave_present),
                           8'(rsp_payload.slave_present));
            end
         end
         // predict the result of an accepted request beat
         if (req_valid && req_ready)
            predicted_states.push_back(apply_port_write(req_payload));
      end
      outstanding = predicted_states.size();
   end

endmodule

// ----- tb/interrupt_controller_init_write_top_tb.sv -----
// Testbench top for interrupt_controller_init_write_top: drives port writes
// and result back-pressure, and gives the verdict from icw_write_checker.
// Depends on icw_pkg, the block itself and icw_write_checker.
module interrupt_controller_init_write_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import icw_pkg::*;

   localparam logic [7:0] MASTER_CMD  = 8'h00;
   localparam logic [7:0] MASTER_DATA = 8'h01;
   localparam logic [7:0] SLAVE_CMD   = 8'h80;
   localparam logic [7:0] SLAVE_DATA  = 8'h81;
   localparam int RANDOM_WRITES = 650;
   localparam int QUIET_TAIL    = 90;
   localparam int LONG_HOLD     = 300;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;
   int      fail_count;
   int      outstanding;
   int      writes_done;
   bit      idling_on;
   bit      long_hold_pending;
   bit      slave_gone;

   interrupt_controller_init_write_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   icw_write_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #2ms;
      $display("Verification failed");
      $finish;
   end

   // Random port with the chip and data/command bits forced
   function automatic logic [7:0] pick_port(logic chip, logic is_data);
      logic [7:0] p;
      p                 = 8'($urandom_range(0, 255));
      p[PORT_SLAVE_BIT] = chip;
      p[PORT_DATA_BIT]  = is_data;
      return p;
   endfunction

   // Offer one write beat, starting and ending at a falling edge
   task automatic send_write(logic [7:0] port, logic [7:0] data);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid             <= 1'b1;
      req_payload.port_addr <= port;
      req_payload.data      <= data;
      do @(posedge clock); while (!req_ready);
      writes_done++;
      if (!port[PORT_SLAVE_BIT] && !port[PORT_DATA_BIT])
         slave_gone = data[CMD_SINGLE_BIT];
      @(negedge clock);
   endtask

   // Receiver: random stalls, plus one long hold to fill the pipeline
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Stimulus
   initial begin
      logic       c;
      logic       cascade_after;
      logic [7:0] cmd;
      int         n;
      int         pick;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_payload       = '0;
      idling_on         = 1'b1;
      long_hold_pending = 1'b0;
      slave_gone        = 1'b0;
      writes_done       = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // mask extremes on the master
      send_write(MASTER_DATA, 8'hFF);
      send_write(MASTER_DATA, 8'h00);
      // full master init with ICW4 and auto-EOI
      send_write(MASTER_CMD, 8'h11);
      send_write(MASTER_DATA, 8'hFF);
      send_write(MASTER_DATA, 8'h04);
      send_write(MASTER_DATA, 8'h03);
      // slave init without ICW4: ICW3 returns to ready, then a mask write
      send_write(SLAVE_CMD, 8'h10);
      send_write(SLAVE_DATA, 8'h07);
      send_write(SLAVE_DATA, 8'h02);
      send_write(SLAVE_DATA, 8'hA5);
      // restart in the middle of init, then finish it
      send_write(MASTER_CMD, 8'h11);
      send_write(MASTER_CMD, 8'h11);
      send_write(MASTER_DATA, 8'h40);
      send_write(MASTER_DATA, 8'h00);
      send_write(MASTER_DATA, 8'h00);
      // command without the init bit keeps the phase
      send_write(SLAVE_CMD, 8'h01);
      // single mode: ICW2 skips ICW3, slave writes are dropped
      send_write(MASTER_CMD, 8'h13);
      send_write(MASTER_DATA, 8'h20);
      send_write(SLAVE_DATA, 8'h55);
      send_write(SLAVE_CMD, 8'h11);
      send_write(MASTER_DATA, 8'h02);
      send_write(MASTER_CMD, 8'h12);
      send_write(MASTER_DATA, 8'h88);
      // restore the slave; odd port bits are don't-care
      send_write(8'h7E, 8'h00);
      send_write(8'hFF, 8'hFF);
      send_write(8'hFE, 8'hEF);

      writes_done       = 0;
      long_hold_pending = 1'b1;
      while (writes_done < RANDOM_WRITES) begin
         idling_on = (writes_done < RANDOM_WRITES - QUIET_TAIL);
         pick      = $urandom_range(0, 9);
         c         = 1'($urandom_range(0, 1));
         if (pick <= 4) begin
            // init sequence with random content, sometimes cut short
            cmd = 8'($urandom_range(0, 255));
            cmd[CMD_INIT_BIT] = 1'b1;
            if (c == CHIP_MASTER)
               cmd[CMD_SINGLE_BIT] = ($urandom_range(0, 3) == 0);
            cascade_after = (c == CHIP_MASTER) ? !cmd[CMD_SINGLE_BIT] : !slave_gone;
            n = 1 + int'(cascade_after) + int'(cmd[CMD_IC4_BIT]);
            if ($urandom_range(0, 7) == 0)
               n = $urandom_range(0, n - 1);
            send_write(pick_port(c, 1'b0), cmd);
            repeat (n) send_write(pick_port(c, 1'b1), 8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 2))
               send_write(pick_port(c, 1'b1), 8'($urandom_range(0, 255)));
         end else if (pick <= 6) begin
            repeat ($urandom_range(1, 3))
               send_write(pick_port(c, 1'b1), 8'($urandom_range(0, 255)));
         end else if (pick == 7) begin
            cmd = 8'($urandom_range(0, 255));
            cmd[CMD_INIT_BIT] = 1'b0;
            send_write(pick_port(c, 1'b0), cmd);
         end else begin
            send_write(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end
      end
      req_valid <= 1'b0;

      // drain, then allow the pipeline latency
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/icw_pkg.sv
hw/rtl/interrupt_controller_init_write_top.sv
tb/icw_write_checker.sv
tb/interrupt_controller_init_write_top_tb.sv
